// File: sv/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Types, codes and helpers shared by the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int UNIT_W      = 10;
   localparam int TIMEOUT_W   = 16;
   localparam int DELAY_W     = 12;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 1;

   localparam logic [UNIT_W-1:0]    UNIT_TICKS_RESET  = 10'd8;
   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 16'd250;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UNIT_TICKS  = 1'b0,
      CSR_ACK_TIMEOUT = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_START    = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_WRITE    = 3'd3,
      CMD_READ     = 3'd4,
      CMD_WAIT_ACK = 3'd5
   } cmd_type;

   typedef enum logic [15:0] {
      PH_IDLE = 16'b0000_0000_0000_0001,
      PH_S0   = 16'b0000_0000_0000_0010,
      PH_S1   = 16'b0000_0000_0000_0100,
      PH_P0   = 16'b0000_0000_0000_1000,
      PH_P1   = 16'b0000_0000_0001_0000,
      PH_W0   = 16'b0000_0000_0010_0000,
      PH_W1   = 16'b0000_0000_0100_0000,
      PH_W2   = 16'b0000_0000_1000_0000,
      PH_R0   = 16'b0000_0001_0000_0000,
      PH_R1   = 16'b0000_0010_0000_0000,
      PH_R2   = 16'b0000_0100_0000_0000,
      PH_A0   = 16'b0000_1000_0000_0000,
      PH_A1   = 16'b0001_0000_0000_0000,
      PH_K0   = 16'b0010_0000_0000_0000,
      PH_K1   = 16'b0100_0000_0000_0000,
      PH_K2   = 16'b1000_0000_0000_0000
   } phase_type;

   typedef struct packed {
      logic       is_cmd;
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   // Phase length minus one, for one or two delay units; a zero length lasts one tick.
   function automatic logic [DELAY_W-1:0] delay_load(input logic two_units,
                                                     input logic [UNIT_W-1:0] unit_ticks);
      logic [UNIT_W:0] len;
      len = two_units ? {unit_ticks, 1'b0} : {1'b0, unit_ticks};
      if (len == '0) begin
         delay_load = '0;
      end else begin
         delay_load = DELAY_W'(len - 1'b1);
      end
   endfunction

endpackage

// File: sv/i2cmbe_front.sv
// ----------------------------------------------------------------------------
// i2cmbe_front
// Accepts request transactions, classifies the command and queues them.
// ----------------------------------------------------------------------------
module i2cmbe_front #(
   parameter int QUEUE_DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_cmd,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_send_ack,
   input  logic                 req_sda_in,
   output logic                 head_valid,
   output i2cmbe_pkg::item_type head_item,
   input  logic                 head_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   i2cmbe_pkg::item_type queue_mem [QUEUE_DEPTH];
   i2cmbe_pkg::item_type push_item;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign req_stall  = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign push       = req_valid && !req_stall;
   assign pop        = head_pop && head_valid;

   always_comb begin
      push_item.is_cmd    = (req_cmd >= i2cmbe_pkg::CMD_START) &&
                            (req_cmd <= i2cmbe_pkg::CMD_WAIT_ACK);
      push_item.cmd       = i2cmbe_pkg::cmd_type'(req_cmd);
      push_item.data_byte = req_data_byte;
      push_item.send_ack  = req_send_ack;
      push_item.sda_in    = req_sda_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = queue_mem[rd_ptr_ff];

endmodule

// File: sv/i2cmbe_back.sv
// ----------------------------------------------------------------------------
// i2cmbe_back
// Runs queued ticks through the bus phase sequencer and holds the response.
// ----------------------------------------------------------------------------
module i2cmbe_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [i2cmbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [i2cmbe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                  head_valid,
   input  i2cmbe_pkg::item_type                  head_item,
   output logic                                  head_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_scl_level,
   output logic                                  rsp_sda_level,
   output logic                                  rsp_sda_drive,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic [7:0]                            rsp_read_byte,
   output logic                                  rsp_ack_error,
   output logic                                  rsp_cmd_rejected
);

   localparam int UW = i2cmbe_pkg::UNIT_W;
   localparam int TW = i2cmbe_pkg::TIMEOUT_W;
   localparam int DW = i2cmbe_pkg::DELAY_W;

   i2cmbe_pkg::phase_type phase_ff, phase_in;
   logic [UW-1:0] unit_ticks_ff;
   logic [TW-1:0] ack_limit_ff;
   logic [3:0]    bit_count_ff, bit_count_in;
   logic [7:0]    shift_ff, shift_in;
   logic [DW-1:0] delay_ff, delay_in;
   logic [TW-1:0] timeout_ff, timeout_in;
   logic          ack_choice_ff, ack_choice_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic          sda_dir_ff, sda_dir_in;
   logic          error_ff, error_in;
   logic [7:0]    rx_hold_ff, rx_hold_in;
   logic          done_ff, done_in;
   logic          rejected_ff, rejected_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [3:0]    bit_next;
   logic [7:0]    shift_next;

   assign head_pop     = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = head_pop || (rsp_valid_ff && rsp_stall);
   assign bit_next     = bit_count_ff + 1'b1;
   assign shift_next   = {shift_ff[6:0], 1'b0};

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      delay_in      = delay_ff;
      timeout_in    = timeout_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      sda_dir_in    = sda_dir_ff;
      error_in      = error_ff;
      rx_hold_in    = rx_hold_ff;
      done_in       = 1'b0;
      rejected_in   = 1'b0;
      if (phase_ff != i2cmbe_pkg::PH_IDLE) begin
         rejected_in = head_item.is_cmd;
         if (phase_ff == i2cmbe_pkg::PH_K2) begin
            if (!head_item.sda_in) begin
               scl_in   = 1'b0;
               error_in = 1'b0;
               phase_in = i2cmbe_pkg::PH_IDLE;
               done_in  = 1'b1;
            end else if (timeout_ff >= ack_limit_ff) begin
               error_in   = 1'b1;
               sda_dir_in = 1'b1;
               scl_in     = 1'b0;
               sda_in     = 1'b0;
               phase_in   = i2cmbe_pkg::PH_P0;
               delay_in   = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
            end else begin
               timeout_in = timeout_ff + 1'b1;
            end
         end else if (delay_ff != '0) begin
            delay_in = delay_ff - 1'b1;
         end else begin
            unique case (phase_ff)
               i2cmbe_pkg::PH_S0: begin
                  sda_in   = 1'b0;
                  phase_in = i2cmbe_pkg::PH_S1;
                  delay_in = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
               end
               i2cmbe_pkg::PH_S1: begin
                  scl_in   = 1'b0;
                  phase_in = i2cmbe_pkg::PH_IDLE;
                  done_in  = 1'b1;
               end
               i2cmbe_pkg::PH_P0: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = i2cmbe_pkg::PH_P1;
                  delay_in = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
               end
               i2cmbe_pkg::PH_W0: begin
                  scl_in   = 1'b1;
                  phase_in = i2cmbe_pkg::PH_W1;
                  delay_in = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
               end
               i2cmbe_pkg::PH_W1: begin
                  scl_in   = 1'b0;
                  phase_in = i2cmbe_pkg::PH_W2;
                  delay_in = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
               end
               i2cmbe_pkg::PH_W2: begin
                  shift_in     = shift_next;
                  bit_count_in = bit_next;
                  if (bit_next < 4'd8) begin
                     sda_in   = shift_next[7];
                     phase_in = i2cmbe_pkg::PH_W0;
                     delay_in = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
                  end else begin
                     phase_in = i2cmbe_pkg::PH_IDLE;
                     done_in  = 1'b1;
                  end
               end
               i2cmbe_pkg::PH_R0: begin
                  scl_in   = 1'b1;
                  phase_in = i2cmbe_pkg::PH_R1;
                  delay_in = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
               end
               i2cmbe_pkg::PH_R1: begin
                  shift_in = {shift_ff[6:0], head_item.sda_in};
                  scl_in   = 1'b0;
                  phase_in = i2cmbe_pkg::PH_R2;
                  delay_in = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
               end
               i2cmbe_pkg::PH_R2: begin
                  bit_count_in = bit_next;
                  delay_in     = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
                  if (bit_next < 4'd8) begin
                     phase_in = i2cmbe_pkg::PH_R0;
                  end else begin
                     rx_hold_in = shift_ff;
                     scl_in     = 1'b0;
                     sda_dir_in = 1'b1;
                     sda_in     = !ack_choice_ff;
                     phase_in   = i2cmbe_pkg::PH_A0;
                  end
               end
               i2cmbe_pkg::PH_A0: begin
                  scl_in   = 1'b1;
                  phase_in = i2cmbe_pkg::PH_A1;
                  delay_in = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
               end
               i2cmbe_pkg::PH_A1: begin
                  scl_in   = 1'b0;
                  phase_in = i2cmbe_pkg::PH_IDLE;
                  done_in  = 1'b1;
               end
               i2cmbe_pkg::PH_K0: begin
                  scl_in   = 1'b1;
                  phase_in = i2cmbe_pkg::PH_K1;
                  delay_in = i2cmbe_pkg::delay_load(1'b0, unit_ticks_ff);
               end
               i2cmbe_pkg::PH_K1: begin
                  timeout_in = '0;
                  delay_in   = '0;
                  phase_in   = i2cmbe_pkg::PH_K2;
               end
               default: begin
                  phase_in = i2cmbe_pkg::PH_IDLE;
                  done_in  = 1'b1;
               end
            endcase
         end
      end else if (head_item.is_cmd) begin
         bit_count_in = '0;
         unique case (head_item.cmd)
            i2cmbe_pkg::CMD_START: begin
               sda_dir_in = 1'b1;
               sda_in     = 1'b1;
               scl_in     = 1'b1;
               phase_in   = i2cmbe_pkg::PH_S0;
               delay_in   = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
            end
            i2cmbe_pkg::CMD_STOP: begin
               sda_dir_in = 1'b1;
               scl_in     = 1'b0;
               sda_in     = 1'b0;
               phase_in   = i2cmbe_pkg::PH_P0;
               delay_in   = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
            end
            i2cmbe_pkg::CMD_WRITE: begin
               shift_in   = head_item.data_byte;
               sda_dir_in = 1'b1;
               scl_in     = 1'b0;
               sda_in     = head_item.data_byte[7];
               phase_in   = i2cmbe_pkg::PH_W0;
               delay_in   = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
            end
            i2cmbe_pkg::CMD_READ: begin
               shift_in      = '0;
               ack_choice_in = head_item.send_ack;
               sda_dir_in    = 1'b0;
               sda_in        = 1'b1;
               scl_in        = 1'b0;
               phase_in      = i2cmbe_pkg::PH_R0;
               delay_in      = i2cmbe_pkg::delay_load(1'b1, unit_ticks_ff);
            end
            default: begin
               error_in   = 1'b0;
               sda_dir_in = 1'b0;
               sda_in     = 1'b1;
               phase_in   = i2cmbe_pkg::PH_K0;
               delay_in   = i2cmbe_pkg::delay_load(1'b0, unit_ticks_ff);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= i2cmbe_pkg::UNIT_TICKS_RESET;
         ack_limit_ff  <= i2cmbe_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (i2cmbe_pkg::csr_idx_type'(csr_index))
            i2cmbe_pkg::CSR_UNIT_TICKS:  unit_ticks_ff <= csr_wdata[UW-1:0];
            i2cmbe_pkg::CSR_ACK_TIMEOUT: ack_limit_ff  <= csr_wdata[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cmbe_pkg::PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         delay_ff      <= '0;
         timeout_ff    <= '0;
         ack_choice_ff <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         sda_dir_ff    <= 1'b1;
         error_ff      <= 1'b0;
         rx_hold_ff    <= '0;
         done_ff       <= 1'b0;
         rejected_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (head_pop) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            shift_ff      <= shift_in;
            delay_ff      <= delay_in;
            timeout_ff    <= timeout_in;
            ack_choice_ff <= ack_choice_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            sda_dir_ff    <= sda_dir_in;
            error_ff      <= error_in;
            rx_hold_ff    <= rx_hold_in;
            done_ff       <= done_in;
            rejected_ff   <= rejected_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_level    = scl_ff;
   assign rsp_sda_level    = sda_dir_ff ? sda_ff : 1'b1;
   assign rsp_sda_drive    = sda_dir_ff;
   assign rsp_busy_res     = (phase_ff != i2cmbe_pkg::PH_IDLE);
   assign rsp_done_res     = done_ff;
   assign rsp_read_byte    = rx_hold_ff;
   assign rsp_ack_error    = error_ff;
   assign rsp_cmd_rejected = rejected_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (phase_ff == i2cmbe_pkg::PH_IDLE))
      else $error("done pulse while a command is still running");

   a_delay_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cmbe_pkg::PH_IDLE) |-> (delay_ff == '0))
      else $error("delay counter left running in idle");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit counter past one byte");

   a_error_stop: assert property (@(posedge clock) disable iff (reset)
      $rose(error_ff) |-> (phase_ff == i2cmbe_pkg::PH_P0 && !scl_ff && sda_dir_ff))
      else $error("ack timeout without stop sequence");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(phase_ff) && $stable(delay_ff))
      else $error("state advanced while response was held");

endmodule

// File: sv/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// Tick-driven I2C master: start, stop, byte write, byte read, ack wait.
// ----------------------------------------------------------------------------
// One request transaction is one bus tick and yields exactly one response
// transaction. The engine takes one tick per clock cycle unless the response
// side stalls: the phase sequencer updates its whole state combinationally,
// and a queue of QUEUE_DEPTH entries in front of it plus a response register
// behind it let the request and response sides stall independently. A tick
// passes through the queue, then the response register. Configuration writes
// (ticks per delay unit, ack timeout) take effect on the next cycle and are
// meant to be issued only while no transaction is in flight.
module i2c_master_bit_engine_core #(
   parameter int QUEUE_DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [i2cmbe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2cmbe_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_cmd,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_send_ack,
   input  logic                              req_sda_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_scl_level,
   output logic                              rsp_sda_level,
   output logic                              rsp_sda_drive,
   output logic                              rsp_busy_res,
   output logic                              rsp_done_res,
   output logic [7:0]                        rsp_read_byte,
   output logic                              rsp_ack_error,
   output logic                              rsp_cmd_rejected
);

   logic                 head_valid;
   logic                 head_pop;
   i2cmbe_pkg::item_type head_item;

   i2cmbe_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .req_send_ack  (req_send_ack),
      .req_sda_in    (req_sda_in),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop)
   );

   i2cmbe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_level    (rsp_sda_level),
      .rsp_sda_drive    (rsp_sda_drive),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_ack_error    (rsp_ack_error),
      .rsp_cmd_rejected (rsp_cmd_rejected)
   );

endmodule

// File: bench/i2c_master_bit_engine_core_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_tb
// Self-checking bench for the tick-driven I2C master bit engine.
// ----------------------------------------------------------------------------
// Every request transaction is one bus tick. A cycle-accurate model of the
// phase sequencer runs alongside the engine. It predicts the pin levels, busy,
// done, read byte, ack error and reject flags for each accepted tick, and the
// prediction is compared with the response transaction that comes back.
// Directed tests cover reset settings, single-tick phases, every command,
// rejected and reserved codes, ack seen and ack timeout, the largest timeout
// value and a unit write with the upper data bits set. Random bus transfers
// then run under several settings, with a bursty sender, a stalling receiver
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         WATCHDOG_LIMIT = 2000;
   localparam logic [2:0] CODE_RSVD6     = 3'd6;
   localparam logic [2:0] CODE_RSVD7     = 3'd7;
   localparam int         SDA_LOW        = 0;
   localparam int         SDA_HIGH       = 1;
   localparam int         SDA_RANDOM     = 2;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_byte;
      logic       send_ack;
      logic       sda_in;
   } bus_tick_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_error;
      logic       cmd_rejected;
   } tick_report_type;

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              csr_write = 1'b0;
   logic [i2cmbe_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [i2cmbe_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [2:0]                        req_cmd       = '0;
   logic [7:0]                        req_data_byte = '0;
   logic                              req_send_ack  = 1'b0;
   logic                              req_sda_in    = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_scl_level;
   logic                              rsp_sda_level;
   logic                              rsp_sda_drive;
   logic                              rsp_busy_res;
   logic                              rsp_done_res;
   logic [7:0]                        rsp_read_byte;
   logic                              rsp_ack_error;
   logic                              rsp_cmd_rejected;

   i2c_master_bit_engine_core dut (.*);

   // model state
   logic [i2cmbe_pkg::UNIT_W-1:0]    cfg_unit;
   logic [i2cmbe_pkg::TIMEOUT_W-1:0] cfg_limit;
   i2cmbe_pkg::phase_type            eng_phase;
   logic [3:0]                       eng_bits;
   logic [7:0]                       eng_shift;
   logic [i2cmbe_pkg::DELAY_W-1:0]   eng_delay;
   logic [i2cmbe_pkg::TIMEOUT_W-1:0] eng_polls;
   logic                             eng_ack_sel;
   logic                             eng_scl;
   logic                             eng_sda;
   logic                             eng_dir;
   logic                             eng_err;
   logic [7:0]                       eng_rx;

   tick_report_type expected_reports[$];
   bus_tick_type    cmd_plan[$];
   int              mismatches      = 0;
   int              burst_left      = 0;
   bit              sender_gaps     = 1'b1;
   int              rsp_hold_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void enter_phase(input i2cmbe_pkg::phase_type next, input int units);
      logic [i2cmbe_pkg::DELAY_W-1:0] len;
      len = i2cmbe_pkg::DELAY_W'(units * cfg_unit);
      if (len == '0) len = i2cmbe_pkg::DELAY_W'(1);
      eng_phase = next;
      eng_delay = len - 1'b1;
   endfunction

   function automatic tick_report_type predict_report(input bus_tick_type t);
      tick_report_type r;
      logic            done;
      logic            is_cmd;
      done   = 1'b0;
      is_cmd = (t.cmd >= i2cmbe_pkg::CMD_START) && (t.cmd <= i2cmbe_pkg::CMD_WAIT_ACK);
      r      = '0;
      if (eng_phase != i2cmbe_pkg::PH_IDLE) begin
         r.cmd_rejected = is_cmd;
         if (eng_phase == i2cmbe_pkg::PH_K2) begin
            if (!t.sda_in) begin
               eng_scl   = 1'b0;
               eng_err   = 1'b0;
               eng_phase = i2cmbe_pkg::PH_IDLE;
               done      = 1'b1;
            end else if (eng_polls >= cfg_limit) begin
               eng_err = 1'b1;
               eng_dir = 1'b1;
               eng_scl = 1'b0;
               eng_sda = 1'b0;
               enter_phase(i2cmbe_pkg::PH_P0, 2);
            end else begin
               eng_polls = eng_polls + 1'b1;
            end
         end else if (eng_delay != '0) begin
            eng_delay = eng_delay - 1'b1;
         end else begin
            case (eng_phase)
               i2cmbe_pkg::PH_S0: begin
                  eng_sda = 1'b0;
                  enter_phase(i2cmbe_pkg::PH_S1, 2);
               end
               i2cmbe_pkg::PH_S1: begin
                  eng_scl   = 1'b0;
                  eng_phase = i2cmbe_pkg::PH_IDLE;
                  done      = 1'b1;
               end
               i2cmbe_pkg::PH_P0: begin
                  eng_scl = 1'b1;
                  eng_sda = 1'b1;
                  enter_phase(i2cmbe_pkg::PH_P1, 2);
               end
               i2cmbe_pkg::PH_W0: begin
                  eng_scl = 1'b1;
                  enter_phase(i2cmbe_pkg::PH_W1, 2);
               end
               i2cmbe_pkg::PH_W1: begin
                  eng_scl = 1'b0;
                  enter_phase(i2cmbe_pkg::PH_W2, 2);
               end
               i2cmbe_pkg::PH_W2: begin
                  eng_shift = {eng_shift[6:0], 1'b0};
                  eng_bits  = eng_bits + 1'b1;
                  if (eng_bits < 4'd8) begin
                     eng_sda = eng_shift[7];
                     enter_phase(i2cmbe_pkg::PH_W0, 2);
                  end else begin
                     eng_phase = i2cmbe_pkg::PH_IDLE;
                     done      = 1'b1;
                  end
               end
               i2cmbe_pkg::PH_R0: begin
                  eng_scl = 1'b1;
                  enter_phase(i2cmbe_pkg::PH_R1, 2);
               end
               i2cmbe_pkg::PH_R1: begin
                  eng_shift = {eng_shift[6:0], t.sda_in};
                  eng_scl   = 1'b0;
                  enter_phase(i2cmbe_pkg::PH_R2, 2);
               end
               i2cmbe_pkg::PH_R2: begin
                  eng_bits = eng_bits + 1'b1;
                  if (eng_bits < 4'd8) begin
                     enter_phase(i2cmbe_pkg::PH_R0, 2);
                  end else begin
                     eng_rx  = eng_shift;
                     eng_scl = 1'b0;
                     eng_dir = 1'b1;
                     eng_sda = !eng_ack_sel;
                     enter_phase(i2cmbe_pkg::PH_A0, 2);
                  end
               end
               i2cmbe_pkg::PH_A0: begin
                  eng_scl = 1'b1;
                  enter_phase(i2cmbe_pkg::PH_A1, 2);
               end
               i2cmbe_pkg::PH_A1: begin
                  eng_scl   = 1'b0;
                  eng_phase = i2cmbe_pkg::PH_IDLE;
                  done      = 1'b1;
               end
               i2cmbe_pkg::PH_K0: begin
                  eng_scl = 1'b1;
                  enter_phase(i2cmbe_pkg::PH_K1, 1);
               end
               i2cmbe_pkg::PH_K1: begin
                  eng_polls = '0;
                  eng_phase = i2cmbe_pkg::PH_K2;
                  eng_delay = '0;
               end
               default: begin
                  eng_phase = i2cmbe_pkg::PH_IDLE;
                  done      = 1'b1;
               end
            endcase
         end
      end else if (is_cmd) begin
         eng_bits = '0;
         case (t.cmd)
            i2cmbe_pkg::CMD_START: begin
               eng_dir = 1'b1;
               eng_sda = 1'b1;
               eng_scl = 1'b1;
               enter_phase(i2cmbe_pkg::PH_S0, 2);
            end
            i2cmbe_pkg::CMD_STOP: begin
               eng_dir = 1'b1;
               eng_scl = 1'b0;
               eng_sda = 1'b0;
               enter_phase(i2cmbe_pkg::PH_P0, 2);
            end
            i2cmbe_pkg::CMD_WRITE: begin
               eng_shift = t.data_byte;
               eng_dir   = 1'b1;
               eng_scl   = 1'b0;
               eng_sda   = t.data_byte[7];
               enter_phase(i2cmbe_pkg::PH_W0, 2);
            end
            i2cmbe_pkg::CMD_READ: begin
               eng_shift   = '0;
               eng_ack_sel = t.send_ack;
               eng_dir     = 1'b0;
               eng_sda     = 1'b1;
               eng_scl     = 1'b0;
               enter_phase(i2cmbe_pkg::PH_R0, 2);
            end
            default: begin
               eng_err = 1'b0;
               eng_dir = 1'b0;
               eng_sda = 1'b1;
               enter_phase(i2cmbe_pkg::PH_K0, 1);
            end
         endcase
      end
      r.scl_level = eng_scl;
      r.sda_level = eng_dir ? eng_sda : 1'b1;
      r.sda_drive = eng_dir;
      r.busy_res  = (eng_phase != i2cmbe_pkg::PH_IDLE);
      r.done_res  = done;
      r.read_byte = eng_rx;
      r.ack_error = eng_err;
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   task automatic send_tick(input bus_tick_type t);
      int gap;
      @(negedge clock);
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (burst_left != 0) burst_left--;
      req_valid     <= 1'b1;
      req_cmd       <= t.cmd;
      req_data_byte <= t.data_byte;
      req_send_ack  <= t.send_ack;
      req_sda_in    <= t.sda_in;
      do @(posedge clock); while (req_stall);
      expected_reports.push_back(predict_report(t));
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic set_config(input int unit, input int limit);
      bus_tick_type t;
      t = '0;
      while (eng_phase != i2cmbe_pkg::PH_IDLE) send_tick(t);
      release_req();
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= i2cmbe_pkg::CSR_UNIT_TICKS;
      csr_wdata <= i2cmbe_pkg::CSR_DATA_W'(unit);
      @(negedge clock);
      csr_index <= i2cmbe_pkg::CSR_ACK_TIMEOUT;
      csr_wdata <= i2cmbe_pkg::CSR_DATA_W'(limit);
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_unit  = i2cmbe_pkg::UNIT_W'(unit);
      cfg_limit = i2cmbe_pkg::TIMEOUT_W'(limit);
   endtask

   task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] data, input logic ack,
                          input int sda_mode);
      bus_tick_type t;
      t = '{cmd: cmd, data_byte: data, send_ack: ack, sda_in: 1'($urandom)};
      send_tick(t);
      while (eng_phase != i2cmbe_pkg::PH_IDLE) begin
         t.cmd    = i2cmbe_pkg::CMD_NONE;
         t.sda_in = (sda_mode == SDA_RANDOM) ? 1'($urandom) : (sda_mode == SDA_HIGH);
         send_tick(t);
      end
   endtask

   task automatic plan_transfer();
      bus_tick_type t;
      int           n;
      t = '0;
      if ($urandom_range(0, 7) == 0) begin
         t.cmd       = 3'($urandom_range(i2cmbe_pkg::CMD_START, i2cmbe_pkg::CMD_WAIT_ACK));
         t.data_byte = 8'($urandom);
         t.send_ack  = 1'($urandom);
         cmd_plan.push_back(t);
      end else begin
         t.cmd = i2cmbe_pkg::CMD_START;
         cmd_plan.push_back(t);
         t.cmd       = i2cmbe_pkg::CMD_WRITE;
         t.data_byte = 8'($urandom);
         cmd_plan.push_back(t);
         t.cmd = i2cmbe_pkg::CMD_WAIT_ACK;
         cmd_plan.push_back(t);
         n = $urandom_range(1, 3);
         repeat (n) begin
            if ($urandom_range(0, 1) == 0) begin
               t.cmd       = i2cmbe_pkg::CMD_WRITE;
               t.data_byte = 8'($urandom);
               cmd_plan.push_back(t);
               t.cmd = i2cmbe_pkg::CMD_WAIT_ACK;
               cmd_plan.push_back(t);
            end else begin
               t.cmd      = i2cmbe_pkg::CMD_READ;
               t.send_ack = 1'($urandom);
               cmd_plan.push_back(t);
            end
         end
         t.cmd = i2cmbe_pkg::CMD_STOP;
         cmd_plan.push_back(t);
      end
   endtask

   task automatic random_ticks(input int count, input int ack_odds);
      bus_tick_type t;
      bus_tick_type planned;
      int           pick;
      for (int i = 0; i < count; i++) begin
         t.data_byte = 8'($urandom);
         t.send_ack  = 1'($urandom);
         t.sda_in    = (eng_phase == i2cmbe_pkg::PH_K2) ? ($urandom_range(0, ack_odds) != 0)
                                                        : 1'($urandom);
         if (eng_phase == i2cmbe_pkg::PH_IDLE) begin
            if ($urandom_range(0, 3) == 0) begin
               pick  = $urandom_range(0, 2);
               t.cmd = (pick == 0) ? i2cmbe_pkg::CMD_NONE :
                       (pick == 1) ? CODE_RSVD6 : CODE_RSVD7;
            end else begin
               if (cmd_plan.size() == 0) plan_transfer();
               planned     = cmd_plan.pop_front();
               t.cmd       = planned.cmd;
               t.data_byte = planned.data_byte;
               t.send_ack  = planned.send_ack;
            end
         end else begin
            t.cmd = ($urandom_range(0, 9) == 0) ?
                    3'($urandom_range(i2cmbe_pkg::CMD_START, CODE_RSVD7)) :
                    i2cmbe_pkg::CMD_NONE;
         end
         send_tick(t);
      end
   endtask

   task automatic test_reset_settings();
      run_cmd(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM);
      run_cmd(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
   endtask

   task automatic test_single_tick_phases();
      set_config(0, 3);
      run_cmd(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      run_cmd(i2cmbe_pkg::CMD_WRITE, 8'h00, 1'b1, SDA_RANDOM);
      run_cmd(i2cmbe_pkg::CMD_WRITE, 8'hFF, 1'b0, SDA_RANDOM);
      run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
      run_cmd(i2cmbe_pkg::CMD_READ, 8'h00, 1'b1, SDA_HIGH);
      run_cmd(i2cmbe_pkg::CMD_READ, 8'hFF, 1'b0, SDA_LOW);
      run_cmd(i2cmbe_pkg::CMD_READ, 8'($urandom), 1'b1, SDA_RANDOM);
      run_cmd(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
   endtask

   task automatic test_rejected_codes();
      bus_tick_type t;
      set_config(2, 4);
      t = '{cmd: CODE_RSVD6, data_byte: 8'hFF, send_ack: 1'b1, sda_in: 1'b1};
      send_tick(t);
      t.cmd = CODE_RSVD7;
      send_tick(t);
      t = '{cmd: i2cmbe_pkg::CMD_START, data_byte: 8'h00, send_ack: 1'b0, sda_in: 1'b0};
      send_tick(t);
      for (int c = i2cmbe_pkg::CMD_START; c <= CODE_RSVD7; c++) begin
         t.cmd = 3'(c);
         send_tick(t);
      end
      run_cmd(i2cmbe_pkg::CMD_NONE, 8'h00, 1'b0, SDA_RANDOM);
   endtask

   task automatic test_ack_timeout();
      set_config(1, 1);
      run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);
      run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
      set_config(0, 2);
      run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);
      run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM);
   endtask

   task automatic test_largest_settings();
      // upper data bits above the unit field drop, leaving three ticks per unit
      set_config(32'h0000_FC03, 65535);
      run_cmd(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM);
      run_cmd(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
   endtask

   task automatic test_receiver_hold();
      set_config(1, 6);
      sender_gaps     = 1'b0;
      rsp_hold_cycles = 100;
      random_ticks(60, 4);
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_transfers();
      int units[5] = '{0, 1, 0, 2, 1};
      int limits[5] = '{3, 6, 1, 20, 250};
      int odds[5] = '{3, 4, 2, 6, 8};
      for (int i = 0; i < 5; i++) begin
         set_config(units[i], limits[i]);
         cmd_plan.delete();
         random_ticks(110, odds[i]);
      end
   endtask

   initial begin : rsp_side
      stall_mode_type mode;
      int             span;
      mode = STALL_NONE;
      span = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_PERIODIC));
               span = $urandom_range(8, 80);
            end
            span--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
               default:     rsp_stall <= (span % 3 == 0);
            endcase
         end
      end
   end

   initial begin : rsp_check
      tick_report_type want;
      tick_report_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            got = '{rsp_scl_level, rsp_sda_level, rsp_sda_drive, rsp_busy_res, rsp_done_res,
                    rsp_read_byte, rsp_ack_error, rsp_cmd_rejected};
            if (expected_reports.size() == 0) begin
               mismatches++;
               $display("%0t ns: unexpected response, expected none actual %h", $time, got);
            end else begin
               want = expected_reports.pop_front();
               check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
               check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
               check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
               check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(got.done_res));
               check_field("read_byte", want.read_byte, got.read_byte);
               check_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
               check_field("cmd_rejected", 8'(want.cmd_rejected), 8'(got.cmd_rejected));
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      cfg_unit    = i2cmbe_pkg::UNIT_TICKS_RESET;
      cfg_limit   = i2cmbe_pkg::ACK_TIMEOUT_RESET;
      eng_phase   = i2cmbe_pkg::PH_IDLE;
      eng_bits    = '0;
      eng_shift   = '0;
      eng_delay   = '0;
      eng_polls   = '0;
      eng_ack_sel = 1'b0;
      eng_scl     = 1'b1;
      eng_sda     = 1'b1;
      eng_dir     = 1'b1;
      eng_err     = 1'b0;
      eng_rx      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_single_tick_phases();
      test_rejected_codes();
      test_ack_timeout();
      test_largest_settings();
      test_receiver_hold();
      test_random_transfers();

      release_req();
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
